// File: rtl/tgr_pkg.sv
// ----------------------------------------------------------------------------
// tgr_pkg
// Shared widths and register codes for the tiled grid to raster reorder block.
// ----------------------------------------------------------------------------
`default_nettype none

package tgr_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned IDX_W   = 30;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIM_X      = 2'd0,
    CFG_DIM_Y      = 2'd1,
    CFG_DIM_Z      = 2'd2,
    CFG_BLOCK_EDGE = 2'd3
  } cfg_idx_e;

endpackage

`default_nettype wire

// File: rtl/tgr_stream_if.sv
// ----------------------------------------------------------------------------
// tgr_stream_if
// Valid/ready channels: grid words in, indexed words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tgr_in_if;
  logic                        valid;
  logic                        ready;
  logic [tgr_pkg::WORD_W-1:0]  in_word;

  modport source (output valid, output in_word, input ready);
  modport sink   (input valid, input in_word, output ready);
endinterface

interface tgr_out_if;
  logic                        valid;
  logic                        ready;
  logic [tgr_pkg::IDX_W-1:0]   raster_index;
  logic [tgr_pkg::WORD_W-1:0]  out_word;
  logic                        last_item;

  modport source (output valid, output raster_index, output out_word, output last_item,
                  input ready);
  modport sink   (input valid, input raster_index, input out_word, input last_item,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/tiled_grid_to_raster_reorder_top.sv
// ----------------------------------------------------------------------------
// tiled_grid_to_raster_reorder_top
// Tags grid words arriving in cubic-tile order with their raster index.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one 64-bit grid word per handshake, in tile order (x-tile,
//   y-tile, z-tile outer; x, y, z inside a tile, tiles clipped to the grid).
//   out_o returns the same word with raster_index = x*dy*dz + y*dz + z and
//   last_item set on the final grid point; the walk then starts over.
//   Registers dim_x, dim_y, dim_z and block_edge (index 0..3) are written
//   through cfg_we_i/cfg_idx_i/cfg_data_i while the block is idle; a write
//   restarts the walk. Zero reads as one, values above MAX_DIM as MAX_DIM.
//   An accepted word goes into the point register and then into the result
//   register, where out_o shows it as valid; one word per cycle is sustained
//   while the receiver keeps ready high, set by the point register and the
//   result register around the index multiply-add. A stalled receiver holds
//   the result register; if the point register is empty one more word still
//   enters it before in_i.ready drops. Reset sets all registers to 1, clears
//   the walk and empties both stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tiled_grid_to_raster_reorder_top #(
  parameter int unsigned MAX_DIM = 1024
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [tgr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [tgr_pkg::CFG_W-1:0]       cfg_data_i,
  tgr_in_if.sink                               in_i,
  tgr_out_if.source                            out_o
);

  localparam int unsigned CW = $clog2(MAX_DIM);
  localparam int unsigned DW = $clog2(MAX_DIM + 1);

  logic [CW-1:0] pt_x, pt_y, pt_z;
  logic [DW-1:0] dim_y, dim_z;
  logic          walk_last;
  logic          step;

  assign step = in_i.valid && in_i.ready;

  tgr_walk #(
    .MAX_DIM (MAX_DIM)
  ) u_walk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (step),
    .pt_x_o     (pt_x),
    .pt_y_o     (pt_y),
    .pt_z_o     (pt_z),
    .last_o     (walk_last),
    .dim_y_o    (dim_y),
    .dim_z_o    (dim_z)
  );

  tgr_index #(
    .MAX_DIM (MAX_DIM)
  ) u_index (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_i.valid),
    .in_ready_o     (in_i.ready),
    .in_word_i      (in_i.in_word),
    .pt_x_i         (pt_x),
    .pt_y_i         (pt_y),
    .pt_z_i         (pt_z),
    .last_i         (walk_last),
    .dim_y_i        (dim_y),
    .dim_z_i        (dim_z),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .raster_index_o (out_o.raster_index),
    .out_word_o     (out_o.out_word),
    .last_item_o    (out_o.last_item)
  );

endmodule

`default_nettype wire

// File: rtl/tgr_walk.sv
// ----------------------------------------------------------------------------
// tgr_walk
// Config registers and the tile-order point counters; advances once per word.
// ----------------------------------------------------------------------------
`default_nettype none

module tgr_walk #(
  parameter int unsigned MAX_DIM = 1024,
  localparam int unsigned CW = $clog2(MAX_DIM),
  localparam int unsigned DW = $clog2(MAX_DIM + 1)
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [tgr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [tgr_pkg::CFG_W-1:0]       cfg_data_i,
  input  wire logic                            step_i,
  output logic      [CW-1:0]                   pt_x_o,
  output logic      [CW-1:0]                   pt_y_o,
  output logic      [CW-1:0]                   pt_z_o,
  output logic                                 last_o,
  output logic      [DW-1:0]                   dim_y_o,
  output logic      [DW-1:0]                   dim_z_o
);

  localparam int unsigned CMPW = (DW > tgr_pkg::CFG_W) ? DW : tgr_pkg::CFG_W;
  localparam int unsigned EW   = DW + 1;

  // zero reads as one, oversize reads as the maximum
  function automatic logic [DW-1:0] clamp_dim(input logic [tgr_pkg::CFG_W-1:0] v);
    logic [CMPW-1:0] vw;
    vw = CMPW'(v);
    if (vw == '0) begin
      return DW'(1);
    end else if (vw > CMPW'(MAX_DIM)) begin
      return DW'(MAX_DIM);
    end
    return DW'(vw);
  endfunction

  logic [DW-1:0] dx_q, dx_d, dy_q, dy_d, dz_q, dz_d, edge_q, edge_d;
  logic [CW-1:0] tx_q, tx_d, ty_q, ty_d, tz_q, tz_d;
  logic [CW-1:0] px_q, px_d, py_q, py_d, pz_q, pz_d;

  logic [EW-1:0] tx_end, ty_end, tz_end;
  logic [EW-1:0] ex, ey, ez;
  logic [EW-1:0] px_inc, py_inc, pz_inc;
  logic          more_z, more_y, more_x;
  logic          last_tx, last_ty, last_tz, last;

  always_comb begin
    tx_end  = EW'(tx_q) + EW'(edge_q);
    ty_end  = EW'(ty_q) + EW'(edge_q);
    tz_end  = EW'(tz_q) + EW'(edge_q);
    ex      = (tx_end < EW'(dx_q)) ? tx_end : EW'(dx_q);
    ey      = (ty_end < EW'(dy_q)) ? ty_end : EW'(dy_q);
    ez      = (tz_end < EW'(dz_q)) ? tz_end : EW'(dz_q);
    px_inc  = EW'(px_q) + EW'(1);
    py_inc  = EW'(py_q) + EW'(1);
    pz_inc  = EW'(pz_q) + EW'(1);
    more_x  = px_inc < ex;
    more_y  = py_inc < ey;
    more_z  = pz_inc < ez;
    last_tx = tx_end >= EW'(dx_q);
    last_ty = ty_end >= EW'(dy_q);
    last_tz = tz_end >= EW'(dz_q);
    last    = !more_x && !more_y && !more_z && last_tx && last_ty && last_tz;
  end

  always_comb begin
    dx_d   = dx_q;
    dy_d   = dy_q;
    dz_d   = dz_q;
    edge_d = edge_q;
    tx_d   = tx_q;
    ty_d   = ty_q;
    tz_d   = tz_q;
    px_d   = px_q;
    py_d   = py_q;
    pz_d   = pz_q;
    if (cfg_we_i) begin
      case (tgr_pkg::cfg_idx_e'(cfg_idx_i))
        tgr_pkg::CFG_DIM_X:      dx_d   = clamp_dim(cfg_data_i);
        tgr_pkg::CFG_DIM_Y:      dy_d   = clamp_dim(cfg_data_i);
        tgr_pkg::CFG_DIM_Z:      dz_d   = clamp_dim(cfg_data_i);
        tgr_pkg::CFG_BLOCK_EDGE: edge_d = clamp_dim(cfg_data_i);
        default: ;
      endcase
      // a register write restarts the walk
      tx_d = '0;
      ty_d = '0;
      tz_d = '0;
      px_d = '0;
      py_d = '0;
      pz_d = '0;
    end else if (step_i) begin
      if (last) begin
        tx_d = '0;
        ty_d = '0;
        tz_d = '0;
        px_d = '0;
        py_d = '0;
        pz_d = '0;
      end else if (more_z) begin
        pz_d = pz_inc[CW-1:0];
      end else if (more_y) begin
        pz_d = tz_q;
        py_d = py_inc[CW-1:0];
      end else if (more_x) begin
        pz_d = tz_q;
        py_d = ty_q;
        px_d = px_inc[CW-1:0];
      end else begin
        // next tile: z-tile fastest, then y-tile, then x-tile
        if (!last_tz) begin
          tz_d = tz_end[CW-1:0];
        end else begin
          tz_d = '0;
          if (!last_ty) begin
            ty_d = ty_end[CW-1:0];
          end else begin
            ty_d = '0;
            tx_d = last_tx ? '0 : tx_end[CW-1:0];
          end
        end
        px_d = tx_d;
        py_d = ty_d;
        pz_d = tz_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dx_q   <= DW'(1);
      dy_q   <= DW'(1);
      dz_q   <= DW'(1);
      edge_q <= DW'(1);
      tx_q   <= '0;
      ty_q   <= '0;
      tz_q   <= '0;
      px_q   <= '0;
      py_q   <= '0;
      pz_q   <= '0;
    end else begin
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      dz_q   <= dz_d;
      edge_q <= edge_d;
      tx_q   <= tx_d;
      ty_q   <= ty_d;
      tz_q   <= tz_d;
      px_q   <= px_d;
      py_q   <= py_d;
      pz_q   <= pz_d;
    end
  end

  assign pt_x_o  = px_q;
  assign pt_y_o  = py_q;
  assign pt_z_o  = pz_q;
  assign last_o  = last;
  assign dim_y_o = dy_q;
  assign dim_z_o = dz_q;

endmodule

`default_nettype wire

// File: rtl/tgr_index.sv
// ----------------------------------------------------------------------------
// tgr_index
// Two-stage datapath: point register, then raster index and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tgr_index #(
  parameter int unsigned MAX_DIM = 1024,
  localparam int unsigned CW = $clog2(MAX_DIM),
  localparam int unsigned DW = $clog2(MAX_DIM + 1)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [tgr_pkg::WORD_W-1:0]   in_word_i,
  input  wire logic [CW-1:0]                pt_x_i,
  input  wire logic [CW-1:0]                pt_y_i,
  input  wire logic [CW-1:0]                pt_z_i,
  input  wire logic                         last_i,
  input  wire logic [DW-1:0]                dim_y_i,
  input  wire logic [DW-1:0]                dim_z_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [tgr_pkg::IDX_W-1:0]    raster_index_o,
  output logic      [tgr_pkg::WORD_W-1:0]   out_word_o,
  output logic                              last_item_o
);

  localparam int unsigned PW = 2 * DW;
  localparam int unsigned SW = CW + PW + 1;

  logic                        s1_v_q, s1_v_d;
  logic [tgr_pkg::WORD_W-1:0]  s1_word_q;
  logic [CW-1:0]               s1_x_q, s1_y_q, s1_z_q;
  logic                        s1_last_q;

  logic                        o_v_q, o_v_d;
  logic [tgr_pkg::IDX_W-1:0]   o_idx_q;
  logic [tgr_pkg::WORD_W-1:0]  o_word_q;
  logic                        o_last_q;

  // user changes plane size only when idle (unchecked); registering is safe
  logic [PW-1:0]               plane_q;
  logic [SW-1:0]               idx_sum;
  logic                        adv_o, adv_s1, in_acc;

  assign adv_o  = !o_v_q || out_ready_i;
  assign adv_s1 = !s1_v_q || adv_o;
  assign in_acc = in_valid_i && adv_s1;

  assign idx_sum = SW'(s1_x_q) * SW'(plane_q)
                 + SW'(s1_y_q) * SW'(dim_z_i)
                 + SW'(s1_z_q);

  always_comb begin
    s1_v_d = s1_v_q;
    o_v_d  = o_v_q;
    if (adv_s1) begin
      s1_v_d = in_valid_i;
    end
    if (adv_o) begin
      o_v_d = s1_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      o_v_q  <= o_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    plane_q <= PW'(dim_y_i) * PW'(dim_z_i);
    if (in_acc) begin
      s1_word_q <= in_word_i;
      s1_x_q    <= pt_x_i;
      s1_y_q    <= pt_y_i;
      s1_z_q    <= pt_z_i;
      s1_last_q <= last_i;
    end
    if (adv_o && s1_v_q) begin
      o_idx_q  <= idx_sum[tgr_pkg::IDX_W-1:0];
      o_word_q <= s1_word_q;
      o_last_q <= s1_last_q;
    end
  end

  assign in_ready_o     = adv_s1;
  assign out_valid_o    = o_v_q;
  assign raster_index_o = o_idx_q;
  assign out_word_o     = o_word_q;
  assign last_item_o    = o_last_q;

endmodule

`default_nettype wire

// File: bench/tiled_grid_to_raster_reorder_top_tb.sv
// ----------------------------------------------------------------------------
// tiled_grid_to_raster_reorder_top_tb
// Streams grid words in tile order through the reorder block and checks the
// raster index, the passed-through word and the last flag of every result
// against a cycle-free walk predictor. Covers the unit grid, zero and
// oversized register values, clipped edge tiles, restarts on register
// writes, random grid shapes and the opening stretch of a grid at the size
// limit along x, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------

module tiled_grid_to_raster_reorder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_DIM       = 1024;
  localparam int unsigned RANDOM_ITEMS  = 370;
  localparam int unsigned LARGEST_ITEMS = 256;

  typedef struct packed {
    logic [tgr_pkg::IDX_W-1:0]  raster_index;
    logic [tgr_pkg::WORD_W-1:0] out_word;
    logic                       last_item;
  } raster_word_t;

  logic                          clk_i  = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we;
  logic [tgr_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [tgr_pkg::CFG_W-1:0]     cfg_data;

  tgr_in_if  in_ch ();
  tgr_out_if out_ch ();

  tiled_grid_to_raster_reorder_top #(
    .MAX_DIM(MAX_DIM)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (in_ch),
    .out_o     (out_ch)
  );

  always #2 clk_i = ~clk_i;

  // walk predictor: register copies and position in the tile walk
  logic [tgr_pkg::CFG_W-1:0] size_x    = 11'd1;
  logic [tgr_pkg::CFG_W-1:0] size_y    = 11'd1;
  logic [tgr_pkg::CFG_W-1:0] size_z    = 11'd1;
  logic [tgr_pkg::CFG_W-1:0] tile_edge = 11'd1;
  logic [tgr_pkg::CFG_W-1:0] corner_x  = '0;
  logic [tgr_pkg::CFG_W-1:0] corner_y  = '0;
  logic [tgr_pkg::CFG_W-1:0] corner_z  = '0;
  logic [tgr_pkg::CFG_W-1:0] at_x      = '0;
  logic [tgr_pkg::CFG_W-1:0] at_y      = '0;
  logic [tgr_pkg::CFG_W-1:0] at_z      = '0;

  raster_word_t expected_q[$];
  int unsigned  mismatch_count = 0;
  int unsigned  burst_left     = 1;
  logic         valid_shadow   = 1'b0;

  function automatic int unsigned clamp_size(input logic [tgr_pkg::CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic void restart_walk();
    corner_x = '0;
    corner_y = '0;
    corner_z = '0;
    at_x     = '0;
    at_y     = '0;
    at_z     = '0;
  endfunction

  function automatic raster_word_t next_raster(input logic [tgr_pkg::WORD_W-1:0] w);
    int unsigned     dx, dy, dz, e, ex, ey, ez;
    longint unsigned pos;
    logic            tile_done, end_tz, end_ty, end_tx, fin;
    raster_word_t    r;
    dx = clamp_size(size_x);
    dy = clamp_size(size_y);
    dz = clamp_size(size_z);
    e  = clamp_size(tile_edge);
    ex = (corner_x + e < dx) ? corner_x + e : dx;
    ey = (corner_y + e < dy) ? corner_y + e : dy;
    ez = (corner_z + e < dz) ? corner_z + e : dz;

    pos = 64'(at_x) * dy * dz + 64'(at_y) * dz + 64'(at_z);
    tile_done = (at_x + 1 >= ex) && (at_y + 1 >= ey) && (at_z + 1 >= ez);
    end_tz = (corner_z + e >= dz);
    end_ty = (corner_y + e >= dy);
    end_tx = (corner_x + e >= dx);
    fin = tile_done && end_tz && end_ty && end_tx;

    r.raster_index = pos[tgr_pkg::IDX_W-1:0];
    r.out_word     = w;
    r.last_item    = fin;

    if (fin) begin
      restart_walk();
    end else if (at_z + 1 < ez) begin
      at_z = at_z + 1'b1;
    end else if (at_y + 1 < ey) begin
      at_z = corner_z;
      at_y = at_y + 1'b1;
    end else if (at_x + 1 < ex) begin
      at_z = corner_z;
      at_y = corner_y;
      at_x = at_x + 1'b1;
    end else begin
      // tile finished: z-tile moves fastest, then y-tile, then x-tile
      if (!end_tz) begin
        corner_z = corner_z + tgr_pkg::CFG_W'(e);
      end else begin
        corner_z = '0;
        if (!end_ty) begin
          corner_y = corner_y + tgr_pkg::CFG_W'(e);
        end else begin
          corner_y = '0;
          corner_x = end_tx ? '0 : corner_x + tgr_pkg::CFG_W'(e);
        end
      end
      at_x = corner_x;
      at_y = corner_y;
      at_z = corner_z;
    end
    return r;
  endfunction

  task automatic set_valid(input logic v);
    if (v != valid_shadow) begin
      in_ch.valid <= v;
      valid_shadow = v;
    end
  endtask

  // bursts of random length, random gaps between them
  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 24);
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        set_valid(1'b0);
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_word(input logic [tgr_pkg::WORD_W-1:0] w);
    set_valid(1'b1);
    in_ch.in_word <= w;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    expected_q.insert(expected_q.size(), next_raster(w));
    pace();
  endtask

  task automatic wait_idle();
    set_valid(1'b0);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_reg(input tgr_pkg::cfg_idx_e idx, input logic [tgr_pkg::CFG_W-1:0] val);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      tgr_pkg::CFG_DIM_X:      size_x = val;
      tgr_pkg::CFG_DIM_Y:      size_y = val;
      tgr_pkg::CFG_DIM_Z:      size_z = val;
      tgr_pkg::CFG_BLOCK_EDGE: tile_edge = val;
      default: ;
    endcase
    restart_walk();
  endtask

  function automatic logic [tgr_pkg::WORD_W-1:0] random_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [tgr_pkg::CFG_W-1:0] random_size(input bit for_edge);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return for_edge ? tgr_pkg::CFG_W'($urandom_range(MAX_DIM, 2047)) : 11'd1;
      default: return tgr_pkg::CFG_W'($urandom_range(1, 6));
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  // reset values: every word is a one-point grid
  task automatic test_unit_grid();
    send_word('0);
    send_word('1);
    send_word(64'hAAAA_AAAA_5555_5555);
  endtask

  // zero reads as one, above-max reads as max, a write restarts mid-walk
  task automatic test_clamped_sizes();
    set_reg(tgr_pkg::CFG_DIM_X, '0);
    set_reg(tgr_pkg::CFG_DIM_Y, '0);
    set_reg(tgr_pkg::CFG_DIM_Z, 11'd2047);
    set_reg(tgr_pkg::CFG_BLOCK_EDGE, '0);
    repeat (6) send_word(random_word());
    set_reg(tgr_pkg::CFG_BLOCK_EDGE, 11'd1025);
    repeat (4) send_word(random_word());
  endtask

  // edge tiles clipped in x and z, then wrap into the next grid
  task automatic test_clipped_tiles();
    set_reg(tgr_pkg::CFG_DIM_X, 11'd3);
    set_reg(tgr_pkg::CFG_DIM_Y, 11'd1);
    set_reg(tgr_pkg::CFG_DIM_Z, 11'd3);
    set_reg(tgr_pkg::CFG_BLOCK_EDGE, 11'd2);
    repeat (11) send_word(random_word());
  endtask

  task automatic test_random_grids();
    int unsigned sent, points, part;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) != 0) set_reg(tgr_pkg::CFG_DIM_X, random_size(1'b0));
      if ($urandom_range(0, 3) != 0) set_reg(tgr_pkg::CFG_DIM_Y, random_size(1'b0));
      if ($urandom_range(0, 3) != 0) set_reg(tgr_pkg::CFG_DIM_Z, random_size(1'b0));
      if ($urandom_range(0, 3) != 0) set_reg(tgr_pkg::CFG_BLOCK_EDGE, random_size(1'b1));
      points = clamp_size(size_x) * clamp_size(size_y) * clamp_size(size_z);
      repeat ($urandom_range(1, 3) * points) begin
        if (sent < RANDOM_ITEMS) begin
          send_word(random_word());
          sent++;
        end
      end
      // grid cut short; the next write starts the walk over
      if (points > 1 && $urandom_range(0, 3) == 0) begin
        part = $urandom_range(1, points - 1);
        repeat (part) begin
          if (sent < RANDOM_ITEMS) begin
            send_word(random_word());
            sent++;
          end
        end
      end
    end
  endtask

  // start of a grid at the size limit along x, edge above the limit
  task automatic test_largest_grid();
    set_reg(tgr_pkg::CFG_DIM_X, 11'd2047);
    set_reg(tgr_pkg::CFG_DIM_Y, 11'd1);
    set_reg(tgr_pkg::CFG_DIM_Z, '0);
    set_reg(tgr_pkg::CFG_BLOCK_EDGE, 11'd2047);
    repeat (LARGEST_ITEMS) send_word(random_word());
  endtask

  // ---------------------------------------------------------------- sink

  initial begin : sink_pattern
    int unsigned mode, run;
    out_ch.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      mode = $urandom_range(0, 3);
      run  = $urandom_range(4, 40);
      repeat (run) begin
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
          2:       out_ch.ready <= 1'($urandom_range(0, 1));
          default: out_ch.ready <= 1'b0;
        endcase
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    raster_word_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("unexpected word: index %0d word %h last %b", out_ch.raster_index,
                   out_ch.out_word, out_ch.last_item);
        end
        mismatch_count++;
      end else begin
        want = expected_q.pop_front();
        if (out_ch.raster_index !== want.raster_index || out_ch.out_word !== want.out_word ||
            out_ch.last_item !== want.last_item) begin
          if (mismatch_count < 10) begin
            $display("mismatch: index %0d/%0d word %h/%h last %b/%b (expected/actual)",
                     want.raster_index, out_ch.raster_index, want.out_word,
                     out_ch.out_word, want.last_item, out_ch.last_item);
          end
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- main

  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.in_word <= '0;
    cfg_we        <= 1'b0;
    cfg_idx       <= tgr_pkg::CFG_DIM_X;
    cfg_data      <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unit_grid();
    test_clamped_sizes();
    test_clipped_tiles();
    test_random_grids();
    test_largest_grid();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("tiled_grid_to_raster_reorder_top_tb: done, clean");
    end else begin
      $display("tiled_grid_to_raster_reorder_top_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tiled_grid_to_raster_reorder_top_tb: done, errors");
    $finish;
  end

endmodule
